FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the cache top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic signed [VAL_W-1:0] val_t;

    // request kinds carried in the input tuser bit
    typedef enum logic {
        REQ_GET = 1'b0,
        REQ_SET = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_COMMIT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic capture;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

FILE: hw/rtl/lkvc_ctrl.sv
// Request sequencer: accept, match, commit.
module lkvc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  lkvc_pkg::dp_status_t  status,
    output lkvc_pkg::dp_cmd_t     cmd
);
    import lkvc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_MATCH;
                end
            end
            ST_MATCH: begin
                cmd.capture = 1'b1;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT: begin
                // wait for room in the output register
                if (!status.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/lkvc_dp.sv
// Entry store, match logic, recency ranks and output register.
module lkvc_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lkvc_pkg::dp_cmd_t           cmd,
    output lkvc_pkg::dp_status_t        status,
    input  logic                        cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]  cfg_wr_data,
    input  logic [63:0]                 s_tdata,
    input  logic [0:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,
    output logic [1:0]                  m_tuser
);
    import lkvc_pkg::*;

    // lowest set bit of a vector
    function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    logic [CAP_W-1:0]   cap_reg;
    key_t               key_reg   [ENTRIES];
    val_t               value_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [RANK_W-1:0]  rank_reg  [ENTRIES];
    logic [RANK_W-1:0]  rank_next [ENTRIES];
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;

    req_t               req_type_reg;
    key_t               req_key_reg;
    val_t               req_value_reg;

    logic               hit_reg;
    logic               room_reg;
    logic [IDX_W-1:0]   found_idx_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [IDX_W-1:0]   victim_idx_reg;
    logic [RANK_W-1:0]  found_rank_reg;

    logic               out_valid_reg;
    logic               out_hit_reg;
    logic               out_evicted_reg;
    val_t               out_value_reg;

    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] lru_vec;
    logic [RANK_W-1:0]  victim_rank;
    logic [CNT_W-1:0]   cap_eff;
    logic [IDX_W-1:0]   found_idx;

    logic               is_set;
    logic               do_insert;
    logic               do_evict;
    logic [IDX_W-1:0]   tgt_idx;
    logic [RANK_W:0]    age_thr;

    // capacity register, clamped into 1..ENTRIES on use
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (cap_reg > CAP_W'(ENTRIES)) begin
            cap_eff = CNT_W'(ENTRIES);
        end else begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_type_reg  <= req_t'(s_tuser[0]);
            req_key_reg   <= s_tdata[31:0];
            req_value_reg <= s_tdata[63:32];
        end
    end

    // parallel compare: key hit, free slot, least recent entry
    assign victim_rank = RANK_W'(fill_reg - 1'b1);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i]  = valid_reg[i] && (key_reg[i] == req_key_reg);
            free_vec[i] = !valid_reg[i];
            lru_vec[i]  = valid_reg[i] && (rank_reg[i] == victim_rank);
        end
    end

    assign found_idx = first_set(hit_vec);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            hit_reg        <= |hit_vec;
            room_reg       <= (fill_reg < cap_eff);
            found_idx_reg  <= found_idx;
            free_idx_reg   <= first_set(free_vec);
            victim_idx_reg <= first_set(lru_vec);
            found_rank_reg <= rank_reg[found_idx];
        end
    end

    // write target and aging threshold for the commit
    assign is_set    = (req_type_reg == REQ_SET);
    assign do_insert = is_set && !hit_reg && room_reg;
    assign do_evict  = is_set && !hit_reg && !room_reg;

    always_comb begin
        if (hit_reg) begin
            tgt_idx = found_idx_reg;
            age_thr = {1'b0, found_rank_reg};
        end else if (room_reg) begin
            // a fresh entry ages every valid one
            tgt_idx = free_idx_reg;
            age_thr = (RANK_W + 1)'(ENTRIES);
        end else begin
            tgt_idx = victim_idx_reg;
            age_thr = {1'b0, victim_rank};
        end
    end

    // recency, valid and fill update
    always_comb begin
        valid_next = valid_reg;
        fill_next  = fill_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            rank_next[i] = rank_reg[i];
        end
        if (cmd.commit && is_set) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (valid_reg[i] && (IDX_W'(i) != tgt_idx)
                    && ({1'b0, rank_reg[i]} < age_thr)) begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
            rank_next[tgt_idx]  = '0;
            valid_next[tgt_idx] = 1'b1;
            if (do_insert) begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fill_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // key and value store
    always_ff @(posedge aclk) begin
        if (cmd.commit && is_set) begin
            key_reg[tgt_idx]   <= req_key_reg;
            value_reg[tgt_idx] <= req_value_reg;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_hit_reg     <= hit_reg;
            out_evicted_reg <= do_evict;
            if (!is_set && hit_reg) begin
                out_value_reg <= value_reg[found_idx_reg];
            end else begin
                out_value_reg <= MISS_VALUE;
            end
        end
    end

    assign status.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_value_reg;
    assign m_tuser         = {out_evicted_reg, out_hit_reg};

endmodule

FILE: hw/rtl/lru_key_value_cache.sv
// Top level of the LRU key-value cache.
// Sixteen-entry fully associative key/value cache with least-recently-used
// replacement. One request is handled at a time: it is accepted, then the key
// is compared against all entries and the free slot and least recent entry
// are encoded, and then a write-back updates the entry and the recency ranks
// and loads the output register. The write-back waits while the previous
// result word is still held, so a new request can be accepted while a result
// waits. A get returns the stored value with hit set, or all ones and hit
// clear, without touching recency; a set returns all ones, hit if the key was
// present, and evicted if the least recent entry was replaced. Capacity is
// clamped into 1..16 on use and may only be written while the block is idle.
`include "assert_macros.svh"

module lru_key_value_cache (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration: capacity
    input  logic                        cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]  cfg_wr_data,
    // request channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,   // [31:0] lookup_key, [63:32] store_value
    input  logic [0:0]                  s_tuser,   // [0] req_type
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // [31:0] read_value
    output logic [1:0]                  m_tuser    // [0] hit, [1] evicted
);
    import lkvc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    lkvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lkvc_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // an accepted request blocks the input until it is written back
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "accepted a word while busy")
    // write-back never overwrites a result word that is still held
    `ASSERT_IMPLIES(a_commit_room, aclk, aresetn, cmd.commit, !(m_tvalid && !m_tready), "result word overwritten")
    // every write-back presents a result word
    `ASSERT_NEXT(a_commit_valid, aclk, aresetn, cmd.commit, m_tvalid, "write-back produced no result")
    // commands are mutually exclusive
    `ASSERT_IMPLIES(a_cmd_onehot, aclk, aresetn, 1'b1, $onehot0(cmd), "overlapping datapath commands")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the LRU key-value cache: predictor, drivers and checks.
`timescale 1ns / 1ps

module testbench;
    import lkvc_pkg::*;

    // one result word as seen on the master side
    typedef struct {
        val_t read_value;
        bit   hit;
        bit   evicted;
    } cache_result_t;

    // Mirror of the cache contents; predicts each result and checks the block's words.
    class cache_mirror;
        bit [KEY_W-1:0]  keys[ENTRIES];
        bit [VAL_W-1:0]  values[ENTRIES];
        bit              valid[ENTRIES];
        int unsigned     rank[ENTRIES];
        int unsigned     fill;
        bit [CAP_W-1:0]  capacity;
        cache_result_t   pending_results[$];
        int              mismatches;
        int              n_results;
        int              n_hits;
        int              n_evictions;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                valid[i] = 1'b0;
                rank[i]  = 0;
            end
            fill        = 0;
            capacity    = CAP_RESET;
            mismatches  = 0;
            n_results   = 0;
            n_hits      = 0;
            n_evictions = 0;
        endfunction

        // entries newer than old_rank age by one, idx becomes most recent
        function void move_to_front(int idx, int unsigned old_rank);
            for (int i = 0; i < ENTRIES; i++) begin
                if (valid[i] && i != idx && rank[i] < old_rank)
                    rank[i]++;
            end
            rank[idx] = 0;
        endfunction

        // accepted request: update the mirror and queue the expected word
        function void note_request(req_t kind, key_t key, val_t value);
            cache_result_t res;
            int            found;
            int            slot;
            int            victim;
            int unsigned   eff_cap;
            int unsigned   worst;
            found   = -1;
            slot    = -1;
            victim  = -1;
            worst   = 0;
            eff_cap = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : capacity;
            for (int i = 0; i < ENTRIES; i++) begin
                if (found < 0 && valid[i] && keys[i] == key)
                    found = i;
            end
            res.hit        = (found >= 0);
            res.read_value = MISS_VALUE;
            res.evicted    = 1'b0;
            if (kind == REQ_GET) begin
                if (found >= 0)
                    res.read_value = values[found];
            end else if (found >= 0) begin
                values[found] = value;
                move_to_front(found, rank[found]);
            end else begin
                if (fill < eff_cap) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot < 0 && !valid[i])
                            slot = i;
                    end
                end
                if (slot >= 0) begin
                    valid[slot]  = 1'b1;
                    keys[slot]   = key;
                    values[slot] = value;
                    move_to_front(slot, 32'hFFFF_FFFF);
                    fill++;
                end else begin
                    // replace the least recent entry, lowest index on a tie
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (valid[i] && (victim < 0 || rank[i] > worst)) begin
                            victim = i;
                            worst  = rank[i];
                        end
                    end
                    if (victim >= 0) begin
                        keys[victim]   = key;
                        values[victim] = value;
                        move_to_front(victim, worst);
                        res.evicted = 1'b1;
                    end
                end
            end
            pending_results.push_back(res);
        endfunction

        // accepted result word: compare with the oldest expectation
        function void check_result(logic [VAL_W-1:0] read_value, logic hit, logic evicted);
            cache_result_t exp_res;
            n_results++;
            if (hit === 1'b1)
                n_hits++;
            if (evicted === 1'b1)
                n_evictions++;
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("ERROR: unexpected word value=%h hit=%b evicted=%b",
                             read_value, hit, evicted);
                mismatches++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (read_value !== exp_res.read_value || hit !== exp_res.hit ||
                evicted !== exp_res.evicted) begin
                if (mismatches < 10)
                    $display({"ERROR: word %0d exp value=%h hit=%b evicted=%b, ",
                              "got value=%h hit=%b evicted=%b"},
                             n_results, exp_res.read_value, exp_res.hit, exp_res.evicted,
                             read_value, hit, evicted);
                mismatches++;
            end
        endfunction

        function bit failed();
            return (mismatches != 0) || (pending_results.size() != 0);
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 108;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata     = '0;   // [31:0] lookup_key, [63:32] store_value
    logic [0:0]           s_tuser     = '0;   // [0] req_type
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [31:0]          m_tdata;            // [31:0] read_value
    logic [1:0]           m_tuser;            // [0] hit, [1] evicted

    cache_mirror mirror = new();

    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int          cycle_count = 0;
    int          n_requests  = 0;
    int          n_cfg       = 0;
    key_t        key_pool[$];

    lru_key_value_cache uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // result side: check accepted words, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            mirror.check_result(m_tdata, m_tuser[0], m_tuser[1]);
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // send one request word, with random idle cycles ahead of it
    task automatic send_request(req_t kind, key_t key, val_t value);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, key};
        s_tuser  <= kind;
        do
            @(posedge aclk);
        while (!s_tready);
        mirror.note_request(kind, key, value);
        n_requests++;
    endtask

    // drain outstanding results, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (mirror.pending_results.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // capacity write while idle
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        mirror.capacity = cap;
        n_cfg++;
    endtask

    function automatic void set_idling(int mode);
        case (mode)
            0: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1: begin
                idle_pct  = 57;
                stall_pct = 0;
            end
            2: begin
                idle_pct  = 0;
                stall_pct = 57;
            end
            default: begin
                idle_pct  = 6;
                stall_pct = 6;
            end
        endcase
    endfunction

    // a key that is mostly from the phase pool, sometimes fresh or extreme
    function automatic key_t pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (roll < 84)
            return (roll < 82) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return $urandom;
    endfunction

    task automatic random_phase(logic [CAP_W-1:0] cap, int mode, int count);
        int   eff_cap;
        req_t kind;
        write_capacity(cap);
        set_idling(mode);
        eff_cap = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
        // pool a little larger than the capacity so hits and evictions both happen
        key_pool.delete();
        repeat (eff_cap + $urandom_range(1, 8))
            key_pool.push_back($urandom);
        repeat (count) begin
            kind = ($urandom_range(0, 1) != 0) ? REQ_SET : REQ_GET;
            send_request(kind, pick_key(), $urandom);
        end
    endtask

    initial begin
        logic [CAP_W-1:0] phase_caps[PHASES];
        phase_caps = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd16, 5'd31,
                       5'd3, 5'd20, 5'd8, 5'd2, 5'd16, 5'd12};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty lookup, extreme keys and values, update, at reset capacity
        set_idling(0);
        send_request(REQ_GET, 32'h0000_0000, 32'h5A5A_5A5A);
        send_request(REQ_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(REQ_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(REQ_SET, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_SET, 32'h0000_0000, 32'h1234_5678);
        send_request(REQ_GET, 32'h0000_0001, 32'hFFFF_FFFF);
        // capacity lowered below the fill level: misses keep evicting
        write_capacity(5'd2);
        send_request(REQ_SET, 32'h0000_0005, 32'h0000_0055);
        send_request(REQ_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(REQ_SET, 32'h0000_0006, 32'h0000_0066);
        send_request(REQ_GET, 32'h0000_0005, 32'h0000_0000);
        send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
        // zero capacity acts as one
        write_capacity(5'd0);
        send_request(REQ_SET, 32'h0000_0007, 32'h0000_0077);
        send_request(REQ_GET, 32'h0000_0007, 32'h0000_0000);
        send_request(REQ_SET, 32'h0000_0007, 32'hCAFE_F00D);
        send_request(REQ_GET, 32'h0000_0006, 32'h0000_0000);
        // capacity above the entry count acts as full size
        write_capacity(5'd31);
        send_request(REQ_SET, 32'h0000_0008, 32'h0000_0088);
        send_request(REQ_GET, 32'h0000_0008, 32'h0000_0000);

        // random phases, cycling through the idling patterns
        for (int p = 0; p < PHASES; p++)
            random_phase(phase_caps[p], p % 4, PHASE_ITEMS);

        wait_idle();
        repeat (10) @(posedge aclk);

        $display("covered %0d requests over %0d capacity settings, %0d result words",
                 n_requests, n_cfg + 1, mirror.n_results);
        $display("of which %0d hits and %0d evictions, %0d mismatches",
                 mirror.n_hits, mirror.n_evictions, mirror.mismatches);
        if (mirror.failed())
            $display("testbench NOT OK");
        else
            $display("testbench OK");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_ctrl.sv
hw/rtl/lkvc_dp.sv
hw/rtl/lru_key_value_cache.sv
tb/testbench.sv
